/* hdl/gaussian_exp2_color_map_assert.svh */
// ----------------------------------------------------------------------------
// Gaussian colour map assertion macros
// Shared concurrent assertion helpers, clocked on clock; GECM_ASSERT is gated by reset.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_EXP2_COLOR_MAP_ASSERT_SVH
`define GAUSSIAN_EXP2_COLOR_MAP_ASSERT_SVH

// Assertion that is switched off while reset is high
`define GECM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion that also holds during reset
`define GECM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/gecm_pkg.sv */
// ----------------------------------------------------------------------------
// Gaussian colour map package
// Widths, register codes, pipeline control types and the exp2 fraction table.
// ----------------------------------------------------------------------------
package gecm_pkg;

   // fraction table resolution
   localparam int EXP_TABLE_BITS = 8;
   localparam int TBL_SIZE       = 1 << EXP_TABLE_BITS;

   localparam int DATA_W  = 16;            // sample, registers and results
   localparam int E2_W    = 2 * DATA_W;    // squared distance
   localparam int XQ_W    = 22;            // exponent Q6.16
   localparam int IP_W    = XQ_W - 16;     // integer part of exponent
   localparam int TBL_W   = 17;            // table entry Q1.16
   localparam int PROD_W  = DATA_W + TBL_W;
   localparam int SH_W    = 7;             // shift amount 16..79
   localparam int XQ_LSB  = 26;            // scale of sharp * e^2

   localparam int NUM_CHAN = 4;            // red, green, blue, alpha
   localparam int NUM_STG  = 6;            // pipeline depth

   localparam logic [DATA_W:0] FULL_SCALE  = 17'd65535;
   localparam logic [SH_W-1:0] SHIFT_BASE  = 7'd16;
   localparam logic [SH_W-1:0] SHIFT_LIMIT = 7'd34;
   localparam logic [DATA_W-1:0] AMP_ONE   = 16'd16384;

   // register indexes
   typedef enum logic [2:0] {
      CSR_RED_SHARP   = 3'd0,
      CSR_GREEN_SHARP = 3'd1,
      CSR_BLUE_SHARP  = 3'd2,
      CSR_ALPHA_SHARP = 3'd3,
      CSR_RED_AMP     = 3'd4,
      CSR_GREEN_AMP   = 3'd5,
      CSR_BLUE_AMP    = 3'd6,
      CSR_ALPHA_AMP   = 3'd7
   } csr_index_type;

   // channel settings, channel 0 red .. 3 alpha
   typedef struct packed {
      logic [NUM_CHAN-1:0][DATA_W-1:0] sharp;
      logic [NUM_CHAN-1:0][DATA_W-1:0] amp;
   } cfg_type;

   // per-stage load enables
   typedef struct packed {
      logic [NUM_STG-1:0] en;
   } stage_ctl_type;

   typedef logic [TBL_W-1:0] exp_entry_type;
   typedef exp_entry_type exp_table_type [TBL_SIZE];

   // floor square root, two bits per step
   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v    = val;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // T[k] = 2^(-k/2^EXP_TABLE_BITS) in Q1.16, built from Q0.31 roots of 0.5
   function automatic exp_table_type build_exp_table();
      logic [63:0]   roots [EXP_TABLE_BITS+1];
      logic [63:0]   r;
      logic [63:0]   acc;
      exp_table_type tbl;
      r        = 64'd1 << 30;
      roots[0] = 64'd1 << 31;
      for (int j = 1; j <= EXP_TABLE_BITS; j++) begin
         r        = isqrt64(r << 31);
         roots[j] = r;
      end
      for (int k = 0; k < TBL_SIZE; k++) begin
         acc = 64'd1 << 31;
         for (int b = 0; b < EXP_TABLE_BITS; b++) begin
            if (((k >> b) & 1) != 0) begin
               acc = (acc * roots[EXP_TABLE_BITS - b] + (64'd1 << 30)) >> 31;
            end
         end
         tbl[k] = TBL_W'((acc + (64'd1 << 14)) >> 15);
      end
      return tbl;
   endfunction

   localparam exp_table_type EXP_TBL = build_exp_table();

endpackage

/* hdl/gecm_req_if.sv */
// ----------------------------------------------------------------------------
// Grey sample channel
// Valid/ready channel that carries one grey sample per beat.
// ----------------------------------------------------------------------------
interface gecm_req_if;
   logic                          valid;
   logic                          ready;
   logic [gecm_pkg::DATA_W-1:0]   grey_sample;

   modport source (output valid, output grey_sample, input ready);
   modport sink   (input valid, input grey_sample, output ready);
endinterface

/* hdl/gecm_rsp_if.sv */
// ----------------------------------------------------------------------------
// Colour result channel
// Valid/ready channel that carries one RGBA colour per beat.
// ----------------------------------------------------------------------------
interface gecm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gecm_pkg::DATA_W-1:0]   red_out;
   logic [gecm_pkg::DATA_W-1:0]   green_out;
   logic [gecm_pkg::DATA_W-1:0]   blue_out;
   logic [gecm_pkg::DATA_W-1:0]   alpha_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output alpha_out, input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   input alpha_out, output ready);
endinterface

/* hdl/gecm_csr.sv */
// ----------------------------------------------------------------------------
// Gaussian colour map settings
// Write-only register file for sharpness and amplitude of each channel.
// ----------------------------------------------------------------------------
module gecm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [2:0]                    csr_index,
   input  logic [gecm_pkg::DATA_W-1:0]   csr_write_data,
   output gecm_pkg::cfg_type             cfg
);

   gecm_pkg::cfg_type cfg_ff;
   gecm_pkg::cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (gecm_pkg::csr_index_type'(csr_index))
            gecm_pkg::CSR_RED_SHARP:   cfg_in.sharp[0] = csr_write_data;
            gecm_pkg::CSR_GREEN_SHARP: cfg_in.sharp[1] = csr_write_data;
            gecm_pkg::CSR_BLUE_SHARP:  cfg_in.sharp[2] = csr_write_data;
            gecm_pkg::CSR_ALPHA_SHARP: cfg_in.sharp[3] = csr_write_data;
            gecm_pkg::CSR_RED_AMP:     cfg_in.amp[0]   = csr_write_data;
            gecm_pkg::CSR_GREEN_AMP:   cfg_in.amp[1]   = csr_write_data;
            gecm_pkg::CSR_BLUE_AMP:    cfg_in.amp[2]   = csr_write_data;
            gecm_pkg::CSR_ALPHA_AMP:   cfg_in.amp[3]   = csr_write_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // reset: zero sharpness, unit amplitude
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < gecm_pkg::NUM_CHAN; c++) begin
            cfg_ff.sharp[c] <= '0;
            cfg_ff.amp[c]   <= gecm_pkg::AMP_ONE;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/gecm_dist.sv */
// ----------------------------------------------------------------------------
// Gaussian colour map distance stages
// Stage 1 distance from mid-grey, stage 2 its square.
// ----------------------------------------------------------------------------
module gecm_dist (
   input  logic                          clock,
   input  gecm_pkg::stage_ctl_type       ctl,
   input  logic [gecm_pkg::DATA_W-1:0]   grey_sample,
   output logic [gecm_pkg::E2_W-1:0]     e2
);

   logic [gecm_pkg::DATA_W:0]     twice;
   logic [gecm_pkg::DATA_W:0]     diff;
   logic [gecm_pkg::DATA_W-1:0]   e_ff;
   logic [gecm_pkg::DATA_W-1:0]   e_in;
   logic [gecm_pkg::E2_W-1:0]     e2_ff;
   logic [gecm_pkg::E2_W-1:0]     e2_in;

   // |2n - 65535|, fits 16 bits
   always_comb begin
      twice = {grey_sample, 1'b0};
      if (twice >= gecm_pkg::FULL_SCALE) begin
         diff = twice - gecm_pkg::FULL_SCALE;
      end else begin
         diff = gecm_pkg::FULL_SCALE - twice;
      end
      e_in  = diff[gecm_pkg::DATA_W-1:0];
      e2_in = e_ff * e_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         e_ff <= e_in;
      end
      if (ctl.en[1]) begin
         e2_ff <= e2_in;
      end
   end

   assign e2 = e2_ff;

endmodule

/* hdl/gecm_chan.sv */
// ----------------------------------------------------------------------------
// Gaussian colour map channel stages
// Stages 3..6 of one channel: exponent, table lookup, scale, shift.
// ----------------------------------------------------------------------------
module gecm_chan (
   input  logic                          clock,
   input  gecm_pkg::stage_ctl_type       ctl,
   input  logic [gecm_pkg::DATA_W-1:0]   sharp,
   input  logic [gecm_pkg::DATA_W-1:0]   amp,
   input  logic [gecm_pkg::E2_W-1:0]     e2,
   output logic [gecm_pkg::DATA_W-1:0]   chan_out
);

   localparam int PX_W = gecm_pkg::DATA_W + gecm_pkg::E2_W;

   logic [PX_W-1:0]                     px;
   logic [gecm_pkg::XQ_W-1:0]           xq_ff;
   logic [gecm_pkg::XQ_W-1:0]           xq_in;
   logic [gecm_pkg::EXP_TABLE_BITS-1:0] idx;
   logic [gecm_pkg::TBL_W-1:0]          tv_ff;
   logic [gecm_pkg::IP_W-1:0]           ip4_ff;
   logic [gecm_pkg::PROD_W-1:0]         prod_ff;
   logic [gecm_pkg::PROD_W-1:0]         prod_in;
   logic [gecm_pkg::IP_W-1:0]           ip5_ff;
   logic [gecm_pkg::SH_W-1:0]           sh;
   logic [gecm_pkg::PROD_W-1:0]         shifted;
   logic [gecm_pkg::DATA_W-1:0]         out_ff;
   logic [gecm_pkg::DATA_W-1:0]         out_in;

   // exponent sharp * d^2 in Q6.16
   always_comb begin
      px    = sharp * e2;
      xq_in = px[gecm_pkg::XQ_LSB +: gecm_pkg::XQ_W];
   end

   // top fraction bits pick the table entry
   assign idx = xq_ff[15 -: gecm_pkg::EXP_TABLE_BITS];

   // amplitude times fraction
   assign prod_in = amp * tv_ff;

   // integer part as right shift; large exponents flush to zero
   always_comb begin
      sh      = gecm_pkg::SHIFT_BASE + gecm_pkg::SH_W'(ip5_ff);
      shifted = prod_ff >> sh;
      if (sh >= gecm_pkg::SHIFT_LIMIT) begin
         out_in = '0;
      end else begin
         out_in = shifted[gecm_pkg::DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         xq_ff <= xq_in;
      end
      if (ctl.en[3]) begin
         tv_ff  <= gecm_pkg::EXP_TBL[idx];
         ip4_ff <= xq_ff[gecm_pkg::XQ_W-1:16];
      end
      if (ctl.en[4]) begin
         prod_ff <= prod_in;
         ip5_ff  <= ip4_ff;
      end
      if (ctl.en[5]) begin
         out_ff <= out_in;
      end
   end

   assign chan_out = out_ff;

endmodule

/* hdl/gaussian_exp2_color_map.sv */
// ----------------------------------------------------------------------------
// Gaussian colour map top level
// Maps a grey sample to RGBA with amp * 2^(-sharp * (n - 0.5)^2) per channel.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one grey sample (unsigned Q0.16) per beat; rsp returns the
//   red, green, blue and alpha results (unsigned Q2.14) of that sample, in
//   order. The csr port writes the eight sharpness/amplitude registers by
//   index; write them only while the pipeline is empty.
//   From an accepted req beat to rsp valid a sample passes the stages
//   distance, square, exponent multiply, table lookup, amplitude multiply, shift.
//   Throughput is one sample per cycle while rsp is ready; the amplitude and
//   exponent multipliers and the table are replicated per channel.
//   Each stage has its own valid bit and loads whenever it is empty or its
//   successor loads, so bubbles close up and req stays ready while stage 6
//   holds a stalled result and earlier stages have room.
//   When rsp is stalled the result holds, and so does every occupied stage
//   with no empty stage after it; nothing is dropped or repeated.
//   Reset clears all valid bits and sets sharpness 0, amplitude 1.0 on every
//   channel, so alpha comes out as constant 1.0 until written.
// ----------------------------------------------------------------------------
`include "gaussian_exp2_color_map_assert.svh"

module gaussian_exp2_color_map (
   input  logic                          clock,
   input  logic                          reset,
   gecm_req_if.sink                      req,
   gecm_rsp_if.source                    rsp,
   input  logic                          csr_write_enable,
   input  logic [2:0]                    csr_index,
   input  logic [gecm_pkg::DATA_W-1:0]   csr_write_data
);

   gecm_pkg::cfg_type                           cfg;
   gecm_pkg::stage_ctl_type                     ctl;
   logic [gecm_pkg::NUM_STG-1:0]                valid_ff;
   logic [gecm_pkg::NUM_STG-1:0]                valid_in;
   logic [gecm_pkg::E2_W-1:0]                   e2;
   logic [gecm_pkg::NUM_CHAN-1:0][gecm_pkg::DATA_W-1:0] chan_out;

   gecm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // stage load enables, from the output back
   always_comb begin
      ctl.en[gecm_pkg::NUM_STG-1] = !valid_ff[gecm_pkg::NUM_STG-1] || rsp.ready;
      for (int s = gecm_pkg::NUM_STG - 2; s >= 0; s--) begin
         ctl.en[s] = !valid_ff[s] || ctl.en[s+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      for (int s = 0; s < gecm_pkg::NUM_STG; s++) begin
         if (ctl.en[s]) begin
            valid_in[s] = (s == 0) ? req.valid : valid_ff[(s == 0) ? 0 : s-1];
         end else begin
            valid_in[s] = valid_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req.ready = ctl.en[0];

   gecm_dist u_dist (
      .clock       (clock),
      .ctl         (ctl),
      .grey_sample (req.grey_sample),
      .e2          (e2)
   );

   for (genvar c = 0; c < gecm_pkg::NUM_CHAN; c++) begin : g_chan
      gecm_chan u_chan (
         .clock    (clock),
         .ctl      (ctl),
         .sharp    (cfg.sharp[c]),
         .amp      (cfg.amp[c]),
         .e2       (e2),
         .chan_out (chan_out[c])
      );
   end

   assign rsp.valid     = valid_ff[gecm_pkg::NUM_STG-1];
   assign rsp.red_out   = chan_out[0];
   assign rsp.green_out = chan_out[1];
   assign rsp.blue_out  = chan_out[2];
   assign rsp.alpha_out = chan_out[3];

   // an accepted beat lands in stage 1
   `GECM_ASSERT(a_enter, req.valid && req.ready |=> valid_ff[0], "accepted beat lost at entry")

   // a stalled result stays put
   `GECM_ASSERT(a_out_hold, rsp.valid && !rsp.ready |=> rsp.valid && $stable(chan_out), "stalled result changed")

   // a full stage that cannot move keeps its beat
   `GECM_ASSERT(a_mid_hold, valid_ff[2] && !ctl.en[3] |=> valid_ff[2], "beat dropped in stage 3")

   // no valid bits right after reset
   `GECM_ASSERT_ALWAYS(a_reset_clear, $past(reset) |-> valid_ff == '0, "valid bits set after reset")

endmodule
